// ===== rtl/core/kabf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kabf_pkg;

  // Datapath word: signed, Q16.16 for angles, Q4.28 for covariances and gains
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_COV   = 28;
  localparam int NOISE_W    = 31;
  localparam int DT_W       = 29;
  // Quotient bits left after the integer overflow check (three integer bits)
  localparam int DIV_STEPS  = DATA_WIDTH - 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  // Datapath operation codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_RATE      = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL_DT_R  = 5'd3;
  localparam logic [OP_W-1:0] OP_ANG_PRED  = 5'd4;
  localparam logic [OP_W-1:0] OP_DTP11     = 5'd5;
  localparam logic [OP_W-1:0] OP_SUB_P10   = 5'd6;
  localparam logic [OP_W-1:0] OP_ADD_QA    = 5'd7;
  localparam logic [OP_W-1:0] OP_MUL_DT_T  = 5'd8;
  localparam logic [OP_W-1:0] OP_P00_PRED  = 5'd9;
  localparam logic [OP_W-1:0] OP_P11_PRED  = 5'd10;
  localparam logic [OP_W-1:0] OP_P10_PRED  = 5'd11;
  localparam logic [OP_W-1:0] OP_INNOV_VAR = 5'd12;
  localparam logic [OP_W-1:0] OP_K0        = 5'd13;
  localparam logic [OP_W-1:0] OP_K1        = 5'd14;
  localparam logic [OP_W-1:0] OP_RESID     = 5'd15;
  localparam logic [OP_W-1:0] OP_MUL_K0Y   = 5'd16;
  localparam logic [OP_W-1:0] OP_ANG_CORR  = 5'd17;
  localparam logic [OP_W-1:0] OP_BIAS_CORR = 5'd18;
  localparam logic [OP_W-1:0] OP_P00_CORR  = 5'd19;
  localparam logic [OP_W-1:0] OP_P01_CORR  = 5'd20;
  localparam logic [OP_W-1:0] OP_P10_CORR  = 5'd21;
  localparam logic [OP_W-1:0] OP_P11_CORR  = 5'd22;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            div_start;
    logic            div_sel;    // 0: divide cov_angle_angle, 1: cov_bias_angle
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Two's complement magnitude; the most negative value maps to 2^(W-1)
  function automatic logic [DATA_WIDTH-1:0] mag(input word_t v);
    return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // (a*b) >> FRAC_COV, magnitude rounded half away from zero, saturated
  function automatic word_t sat_mul(input word_t a, input word_t b);
    logic                        neg;
    logic [2*DATA_WIDTH-1:0]     p;
    logic [DATA_WIDTH+FRAC_COV-1:0] m;
    neg = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    p = {{DATA_WIDTH{1'b0}}, mag(a)} * {{DATA_WIDTH{1'b0}}, mag(b)};
    p = p + ((2*DATA_WIDTH)'(1) << (FRAC_COV - 1));
    m = (DATA_WIDTH+FRAC_COV)'(p >> FRAC_COV);
    if (neg) begin
      if (m > (DATA_WIDTH+FRAC_COV)'(mag(WORD_MIN))) return WORD_MIN;
      return ~m[DATA_WIDTH-1:0] + 1'b1;
    end
    if (m > (DATA_WIDTH+FRAC_COV)'(WORD_MAX)) return WORD_MAX;
    return m[DATA_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kabf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: (n * 2^28) / d, truncated toward zero, one quotient bit a cycle
module kabf_div
  import kabf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire word_t num,
  input  wire word_t den,
  output logic       done,
  output word_t      quot
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-2:0] low;
  logic [DATA_WIDTH-2:0] q;
  logic [DATA_WIDTH-1:0] dm;
  logic                  neg;
  logic                  zero_den;
  logic                  ovf;

  logic [DATA_WIDTH-1:0] nm_in;
  logic [DATA_WIDTH-1:0] dm_in;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;

  assign nm_in = mag(num);
  assign dm_in = mag(den);
  assign trial = {rem, low[DATA_WIDTH-2]};
  assign fits  = trial >= {1'b0, dm};

  // Control: run DIV_STEPS iterations, skip them for zero divisor or overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      done <= 1'b0;
      if (dm_in == '0 ||
          {3'b000, nm_in} >= {dm_in, 3'b000}) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: remainder starts with the integer part already reduced
  always_ff @(posedge clk) begin
    if (start) begin
      dm       <= dm_in;
      neg      <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      zero_den <= (dm_in == '0);
      ovf      <= ({3'b000, nm_in} >= {dm_in, 3'b000});
      rem      <= nm_in >> 3;
      low      <= {nm_in[2:0], {(DATA_WIDTH-4){1'b0}}};
      q        <= '0;
    end else if (busy) begin
      rem <= fits ? DATA_WIDTH'(trial - {1'b0, dm}) : trial[DATA_WIDTH-1:0];
      low <= {low[DATA_WIDTH-3:0], 1'b0};
      q   <= {q[DATA_WIDTH-3:0], fits};
    end
  end

  always_comb begin
    if (zero_den) begin
      quot = '0;
    end else if (ovf) begin
      quot = neg ? WORD_MIN : WORD_MAX;
    end else if (neg) begin
      quot = -$signed({1'b0, q});
    end else begin
      quot = $signed({1'b0, q});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kabf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kabf_datapath
  import kabf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  input  wire logic [3*DATA_WIDTH-1:0] in_data,
  input  wire logic [NOISE_W-1:0]    angle_process_noise,
  input  wire logic [NOISE_W-1:0]    bias_process_noise,
  input  wire logic [NOISE_W-1:0]    measurement_noise,
  output word_t                      filtered_angle
);

  // Filter state
  word_t ang, bias, p00, p01, p10, p11;
  // Per-sample working registers
  word_t meas, rate_in, t, mr, dtp11, s, k0, k1, pa, pb;
  logic [DT_W-1:0] dt;

  word_t dt_w, qa_w, qb_w, rn_w;
  word_t mul_a, mul_b;
  logic  mul_en;
  logic  div_done;
  word_t div_q;

  assign dt_w = word_t'({{(DATA_WIDTH-DT_W){1'b0}}, dt});
  assign qa_w = word_t'({{(DATA_WIDTH-NOISE_W){1'b0}}, angle_process_noise});
  assign qb_w = word_t'({{(DATA_WIDTH-NOISE_W){1'b0}}, bias_process_noise});
  assign rn_w = word_t'({{(DATA_WIDTH-NOISE_W){1'b0}}, measurement_noise});

  kabf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? p10 : p00),
    .den   (s),
    .done  (div_done),
    .quot  (div_q)
  );

  assign status.div_done = div_done;

  // Select the operands of the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      OP_MUL_DT_R:  begin mul_a = dt_w; mul_b = t;   end
      OP_ANG_PRED:  begin mul_a = dt_w; mul_b = p11; end
      OP_MUL_DT_T:  begin mul_a = dt_w; mul_b = t;   end
      OP_P00_PRED:  begin mul_a = qb_w; mul_b = dt_w; end
      OP_MUL_K0Y:   begin mul_a = k0;   mul_b = t;   end
      OP_ANG_CORR:  begin mul_a = k1;   mul_b = t;   end
      OP_BIAS_CORR: begin mul_a = k0;   mul_b = pa;  end
      OP_P00_CORR:  begin mul_a = k0;   mul_b = pb;  end
      OP_P01_CORR:  begin mul_a = k1;   mul_b = pa;  end
      OP_P10_CORR:  begin mul_a = k1;   mul_b = pb;  end
      default:      mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mr <= sat_mul(mul_a, mul_b);
    end
  end

  // Filter state: cleared at reset, updated one operation a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      p00  <= '0;
      p01  <= '0;
      p10  <= '0;
      p11  <= '0;
    end else begin
      unique case (cmd.op)
        OP_ANG_PRED:  ang  <= sat_add(ang, mr);
        OP_P00_PRED:  p00  <= sat_add(p00, mr);
        OP_P11_PRED: begin
          p11 <= sat_add(p11, mr);
          p01 <= sat_sub(p01, dtp11);
        end
        OP_P10_PRED:  p10  <= sat_sub(p10, dtp11);
        OP_ANG_CORR:  ang  <= sat_add(ang, mr);
        OP_BIAS_CORR: bias <= sat_add(bias, mr);
        OP_P00_CORR:  p00  <= sat_sub(p00, mr);
        OP_P01_CORR:  p01  <= sat_sub(p01, mr);
        OP_P10_CORR:  p10  <= sat_sub(p10, mr);
        OP_P11_CORR:  p11  <= sat_sub(p11, mr);
        default: ;
      endcase
    end
  end

  // Working registers and the result register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        meas    <= in_data[DATA_WIDTH-1:0];
        rate_in <= in_data[2*DATA_WIDTH-1:DATA_WIDTH];
        dt      <= in_data[2*DATA_WIDTH+DT_W-1:2*DATA_WIDTH];
      end
      OP_RATE:      t <= sat_sub(rate_in, bias);
      OP_DTP11: begin
        dtp11 <= mr;
        t     <= sat_sub(mr, p01);
      end
      OP_SUB_P10:   t <= sat_sub(t, p10);
      OP_ADD_QA:    t <= sat_add(t, qa_w);
      OP_INNOV_VAR: s <= sat_add(p00, rn_w);
      OP_K0:        if (div_done) k0 <= div_q;
      OP_K1:        if (div_done) k1 <= div_q;
      OP_RESID:     t <= sat_sub(meas, ang);
      OP_ANG_CORR: begin
        pa <= p00;
        pb <= p01;
      end
      OP_P11_CORR:  filtered_angle <= ang;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/kabf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kabf_ctrl
  import kabf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RATE   = 5'd1;
  localparam logic [4:0] ST_MDR    = 5'd2;
  localparam logic [4:0] ST_APRED  = 5'd3;
  localparam logic [4:0] ST_DTP11  = 5'd4;
  localparam logic [4:0] ST_SUBP10 = 5'd5;
  localparam logic [4:0] ST_ADDQA  = 5'd6;
  localparam logic [4:0] ST_MDT    = 5'd7;
  localparam logic [4:0] ST_P00P   = 5'd8;
  localparam logic [4:0] ST_P11P   = 5'd9;
  localparam logic [4:0] ST_P10P   = 5'd10;
  localparam logic [4:0] ST_SVAR   = 5'd11;
  localparam logic [4:0] ST_D0S    = 5'd12;
  localparam logic [4:0] ST_D0W    = 5'd13;
  localparam logic [4:0] ST_D1S    = 5'd14;
  localparam logic [4:0] ST_D1W    = 5'd15;
  localparam logic [4:0] ST_RESID  = 5'd16;
  localparam logic [4:0] ST_MKY    = 5'd17;
  localparam logic [4:0] ST_ACORR  = 5'd18;
  localparam logic [4:0] ST_BCORR  = 5'd19;
  localparam logic [4:0] ST_P00C   = 5'd20;
  localparam logic [4:0] ST_P01C   = 5'd21;
  localparam logic [4:0] ST_P10C   = 5'd22;
  localparam logic [4:0] ST_P11C   = 5'd23;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Sequence the datapath operations
  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = 1'b0;
    unique case (state)
      ST_IDLE: if (s_tvalid) begin
        cmd.op     = OP_LOAD;
        state_next = ST_RATE;
      end
      ST_RATE:   begin cmd.op = OP_RATE;      state_next = ST_MDR;    end
      ST_MDR:    begin cmd.op = OP_MUL_DT_R;  state_next = ST_APRED;  end
      ST_APRED:  begin cmd.op = OP_ANG_PRED;  state_next = ST_DTP11;  end
      ST_DTP11:  begin cmd.op = OP_DTP11;     state_next = ST_SUBP10; end
      ST_SUBP10: begin cmd.op = OP_SUB_P10;   state_next = ST_ADDQA;  end
      ST_ADDQA:  begin cmd.op = OP_ADD_QA;    state_next = ST_MDT;    end
      ST_MDT:    begin cmd.op = OP_MUL_DT_T;  state_next = ST_P00P;   end
      ST_P00P:   begin cmd.op = OP_P00_PRED;  state_next = ST_P11P;   end
      ST_P11P:   begin cmd.op = OP_P11_PRED;  state_next = ST_P10P;   end
      ST_P10P:   begin cmd.op = OP_P10_PRED;  state_next = ST_SVAR;   end
      ST_SVAR:   begin cmd.op = OP_INNOV_VAR; state_next = ST_D0S;    end
      ST_D0S: begin
        cmd.div_start = 1'b1;
        state_next    = ST_D0W;
      end
      ST_D0W: begin
        cmd.op = OP_K0;
        if (status.div_done) state_next = ST_D1S;
      end
      ST_D1S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = ST_D1W;
      end
      ST_D1W: begin
        cmd.op = OP_K1;
        if (status.div_done) state_next = ST_RESID;
      end
      ST_RESID:  begin cmd.op = OP_RESID;     state_next = ST_MKY;    end
      ST_MKY:    begin cmd.op = OP_MUL_K0Y;   state_next = ST_ACORR;  end
      ST_ACORR:  begin cmd.op = OP_ANG_CORR;  state_next = ST_BCORR;  end
      ST_BCORR:  begin cmd.op = OP_BIAS_CORR; state_next = ST_P00C;   end
      ST_P00C:   begin cmd.op = OP_P00_CORR;  state_next = ST_P01C;   end
      ST_P01C:   begin cmd.op = OP_P01_CORR;  state_next = ST_P10C;   end
      ST_P10C:   begin cmd.op = OP_P10_CORR;  state_next = ST_P11C;   end
      // Hold the last update until the result register is free
      ST_P11C: if (out_free) begin
        cmd.op     = OP_P11_CORR;
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_P11_CORR) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_P11_CORR) |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transaction");

  a_start_enters_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == ST_D0W || state == ST_D1W))
    else $error("divider start did not enter its wait state");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_RATE))
    else $error("accepted sample did not start the sequence");

  a_wait_for_quotient: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_D0W || state == ST_D1W) && !status.div_done) |=> $stable(state))
    else $error("left divider wait before the quotient was ready");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/kalman_angle_bias_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-state tilt Kalman filter (angle and gyro bias).
// Input stream s_*: one sample per transaction carrying the accelerometer angle,
// the gyro rate and the time step. Output stream m_*: one filtered angle per sample.
// Configuration: APB registers at 0x0 angle process noise, 0x4 bias process noise,
// 0x8 measurement noise (31-bit Q4.28); write them only while the filter is idle.
// The gain divisions end early, and the result is ready sooner, when the innovation
// variance is zero or a gain saturates. Each of the two gain divisions is a restoring
// divider taking one quotient bit a cycle, with a state to start it and a wait state
// that captures the quotient. The multiplying steps share one multiplier.
// A new sample is accepted as soon as the previous one has reached the output
// register, even if that result still waits.
// If the receiver stalls, the next sample is processed up to its last update and
// held there until the output register is free.
// Reset clears the estimates and covariances to zero and loads the default noise
// values; no initialization sequence is needed.
module kalman_angle_bias_filter_core
  import kabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] measured_angle, [63:32] measured_rate, [92:64] time_step, [95:93] zero
  input  wire logic [95:0] s_tdata,
  // Result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] filtered_angle
  output logic [31:0]      m_tdata,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_ANG_NOISE  = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [NOISE_W-1:0] ANG_NOISE_RST  = NOISE_W'(268435);
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST = NOISE_W'(805306);
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = NOISE_W'(8053064);

  logic [NOISE_W-1:0] angle_process_noise;
  logic [NOISE_W-1:0] bias_process_noise;
  logic [NOISE_W-1:0] measurement_noise;
  logic [1:0]         reg_idx;
  logic               reg_wr;

  dp_cmd_t    cmd;
  dp_status_t status;
  word_t      filtered_angle;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // Write the noise registers; addresses past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_process_noise <= ANG_NOISE_RST;
      bias_process_noise  <= BIAS_NOISE_RST;
      measurement_noise   <= MEAS_NOISE_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ANG_NOISE:  angle_process_noise <= pwdata[NOISE_W-1:0];
        REG_BIAS_NOISE: bias_process_noise  <= pwdata[NOISE_W-1:0];
        REG_MEAS_NOISE: measurement_noise   <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ANG_NOISE:  prdata = {1'b0, angle_process_noise};
      REG_BIAS_NOISE: prdata = {1'b0, bias_process_noise};
      REG_MEAS_NOISE: prdata = {1'b0, measurement_noise};
      default:        prdata = '0;
    endcase
  end

  kabf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  kabf_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_data             (s_tdata),
    .angle_process_noise (angle_process_noise),
    .bias_process_noise  (bias_process_noise),
    .measurement_noise   (measurement_noise),
    .filtered_angle      (filtered_angle)
  );

  assign m_tdata = filtered_angle;

endmodule

`default_nettype wire

// ===== sim/kalman_angle_bias_filter_core_test.sv =====
`timescale 1ns / 1ps

module kalman_angle_bias_filter_core_test;
  import kabf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_ITEMS = 300;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  // Register indexes
  localparam int REG_ANGLE_NOISE = 0;
  localparam int REG_BIAS_NOISE  = 1;
  localparam int REG_MEAS_NOISE  = 2;
  localparam int REG_UNUSED      = 3;
  localparam logic [30:0] NOISE_MAX = 31'h7FFFFFFF;

  // Tilt filter predictor and queue of expected angles
  class angle_scoreboard;
    longint q_angle, q_bias, r_meas;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    logic [31:0] angle_q[$];
    int errors;

    function new();
      q_angle = 268435;
      q_bias = 805306;
      r_meas = 8053064;
      est_angle = 0; est_bias = 0;
      p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      errors = 0;
    endfunction

    function longint clamp(longint v);
      return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
    endfunction

    // Q4.28 product, magnitude rounded half away from zero
    function longint mulq(longint a, longint b);
      bit neg;
      longint unsigned m, cap;
      neg = (a < 0) != (b < 0);
      m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'd1 << 27)) >> 28;
      cap = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > cap) m = cap;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // Gain n/d in Q4.28, truncated toward zero
    function longint divq(longint n, longint d);
      bit neg;
      longint unsigned m, cap;
      if (d == 0) return 0;
      neg = (n < 0) != (d < 0);
      m = ((n < 0 ? -n : n) << 28) / (d < 0 ? -d : d);
      cap = neg ? 64'd2147483648 : 64'd2147483647;
      if (m > cap) m = cap;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function void set_noise(int idx, logic [30:0] v);
      case (idx)
        REG_ANGLE_NOISE: q_angle = v;
        REG_BIAS_NOISE:  q_bias = v;
        REG_MEAS_NOISE:  r_meas = v;
        default: ;
      endcase
    endfunction

    // Advance the filter by one accepted sample and queue its angle
    function void note_sample(logic [95:0] d);
      longint meas, rate, dt, dtp11, s, k0, k1, y, old_aa, old_ab;
      meas = longint'($signed(d[31:0]));
      dt = longint'(d[92:64]);
      rate = clamp(longint'($signed(d[63:32])) - est_bias);
      est_angle = clamp(est_angle + mulq(dt, rate));
      dtp11 = mulq(dt, p_bb);
      p_aa = clamp(p_aa + mulq(dt, clamp(clamp(clamp(dtp11 - p_ab) - p_ba) + q_angle)));
      p_ab = clamp(p_ab - dtp11);
      p_ba = clamp(p_ba - dtp11);
      p_bb = clamp(p_bb + mulq(q_bias, dt));
      s = clamp(p_aa + r_meas);
      k0 = divq(p_aa, s);
      k1 = divq(p_ba, s);
      y = clamp(meas - est_angle);
      est_angle = clamp(est_angle + mulq(k0, y));
      est_bias = clamp(est_bias + mulq(k1, y));
      old_aa = p_aa;
      old_ab = p_ab;
      p_aa = clamp(p_aa - mulq(k0, old_aa));
      p_ab = clamp(p_ab - mulq(k0, old_ab));
      p_ba = clamp(p_ba - mulq(k1, old_aa));
      p_bb = clamp(p_bb - mulq(k1, old_ab));
      angle_q.push_back(est_angle[31:0]);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_angle(logic [31:0] got);
      logic [31:0] want;
      if (angle_q.size() == 0) begin
        report($sformatf("unexpected filtered_angle %h", got));
        return;
      end
      want = angle_q.pop_front();
      if (got !== want) report($sformatf("filtered_angle %h, expected %h", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  angle_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_long = 1'b0;
  int cycles = 0;

  kalman_angle_bias_filter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_angle(m_tdata);
  end

  // Drive receiver ready with random stalls and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_long) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 4'(idx * 4); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_noise(idx, v[30:0]);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] ang, input logic [31:0] rate,
                             input logic [28:0] dt);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {3'b000, dt, rate, ang};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(s_tdata);
  endtask

  // Insert a random input gap, dropping valid for its duration
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
  endtask

  // Wait for all expected angles, then let the datapath settle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.angle_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_angle(int span);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [28:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 29'($urandom);
      1: return 29'($urandom_range(0, 268435456));
      default: return 29'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return NOISE_MAX;
      2: return $urandom_range(0, 1 << 24);
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero noise from a cleared covariance: innovation variance stays zero
    write_reg(REG_ANGLE_NOISE, 0);
    write_reg(REG_BIAS_NOISE, 0);
    write_reg(REG_MEAS_NOISE, 0);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_sample(32'h7FFFFFFF, 32'h80000000, 29'd0);
    send_sample(32'h80000000, 32'h7FFFFFFF, 29'h1FFFFFFF);
    send_sample(32'h00010000, 32'h00640000, 29'd268435);
    drain();

    // Defaults, extremes of every field
    write_reg(REG_ANGLE_NOISE, 268435);
    write_reg(REG_BIAS_NOISE, 805306);
    write_reg(REG_MEAS_NOISE, 8053064);
    send_sample(32'h000A0000, 32'h00010000, 29'd268435);
    send_sample(32'h000B0000, 32'hFFFF0000, 29'd268435);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 29'd268435456);
    send_sample(32'h80000000, 32'h80000000, 29'd268435456);
    send_sample(32'h7FFFFFFF, 32'h80000000, 29'h1FFFFFFF);
    send_sample(32'h00000000, 32'h00000000, 29'd0);
    send_sample(32'h80000000, 32'h7FFFFFFF, 29'h1FFFFFFF);
    send_sample(32'hFFFFFFFF, 32'h00000001, 29'd1);
    drain();

    // Largest noise values
    write_reg(REG_ANGLE_NOISE, NOISE_MAX);
    write_reg(REG_BIAS_NOISE, NOISE_MAX);
    write_reg(REG_MEAS_NOISE, NOISE_MAX);
    send_sample(32'h00050000, 32'h00020000, 29'd268435456);
    send_sample(32'hFFF00000, 32'hFFFE0000, 29'h1FFFFFFF);
    send_sample(32'h7FFFFFFF, 32'h80000000, 29'd268435);
    send_sample(32'h80000000, 32'h7FFFFFFF, 29'd134217728);
    drain();

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ANGLE_NOISE, rand_noise());
      write_reg(REG_BIAS_NOISE, rand_noise());
      write_reg(REG_MEAS_NOISE, rand_noise());
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 20) hold_long = 1'b1;
        send_sample(rand_angle(5898240), rand_angle(32768000), rand_step());
        if (!(ph == 2 && i >= 20 && i < 30)) maybe_gap();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
